FILE: design/mtrd_pkg.sv
// ----------------------------------------------------------------------------
// mtrd_pkg
// Types and constants shared by the MSA track RLE decoder modules.
// ----------------------------------------------------------------------------
package mtrd_pkg;

   localparam int SECTOR_W    = 7;
   localparam int LENGTH_W    = 16;
   localparam int BYTE_W      = 8;
   localparam int TOTAL_W     = 17;
   localparam int SECTOR_SH   = 9;          // 512 bytes per sector
   localparam logic [SECTOR_W-1:0] SECTORS_RESET = 7'd9;
   localparam logic [BYTE_W-1:0]   ESCAPE_BYTE   = 8'hE5;
   localparam logic [LENGTH_W-1:0] ESCAPE_LAST   = 16'd3; // escape needs 4 bytes

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_TRUNC = 2'd1,
      ST_SIZE  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      PH_LITERAL  = 2'd0,
      PH_VALUE    = 2'd1,
      PH_COUNT_HI = 2'd2,
      PH_COUNT_LO = 2'd3
   } phase_type;

   // One classified transaction handed from the front to the back.
   typedef struct packed {
      logic                is_begin;
      logic [LENGTH_W-1:0] length;
      logic [BYTE_W-1:0]   data;
      logic                raw;          // begin: length equals track size
      logic                zero;         // begin: empty track
      logic                size_nonzero; // begin: track size is not zero
      logic                escape;       // data: byte is the escape code
   } item_type;

   function automatic logic [TOTAL_W-1:0] track_size(input logic [SECTOR_W-1:0] sectors);
      track_size = {1'b0, sectors, {SECTOR_SH{1'b0}}};
   endfunction

endpackage

FILE: design/mtrd_front.sv
// ----------------------------------------------------------------------------
// mtrd_front
// Input classifier: decodes the opcode and precomputes track flags.
// ----------------------------------------------------------------------------
module mtrd_front import mtrd_pkg::*; (
   input  logic                req_tuser,
   input  logic [23:0]         req_tdata,
   input  logic [SECTOR_W-1:0] sectors,
   output item_type            item
);

   logic [LENGTH_W-1:0] length;
   logic [TOTAL_W-1:0]  tsize;

   assign length = req_tdata[15:0];
   assign tsize  = track_size(sectors);

   always_comb begin
      item.is_begin     = ~req_tuser;
      item.length       = length;
      item.data         = req_tdata[23:16];
      item.raw          = ({1'b0, length} == tsize);
      item.zero         = (length == '0);
      item.size_nonzero = (tsize != '0);
      item.escape       = (req_tdata[23:16] == ESCAPE_BYTE);
   end

endmodule

FILE: design/mtrd_queue.sv
// ----------------------------------------------------------------------------
// mtrd_queue
// Small FIFO between the classifier and the decode engine.
// ----------------------------------------------------------------------------
module mtrd_queue import mtrd_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output item_type head_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   item_type         entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: design/mtrd_back.sv
// ----------------------------------------------------------------------------
// mtrd_back
// Decode engine: track state, escape sequencing, totals and output register.
// ----------------------------------------------------------------------------
module mtrd_back import mtrd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [SECTOR_W-1:0] sectors,
   input  logic                head_valid,
   input  item_type            head_item,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [23:0]         rsp_tdata,
   output logic                rsp_tlast,
   output logic [1:0]          rsp_tuser
);

   phase_type           phase_ff, phase_in;
   logic                in_track_ff, in_track_in;
   logic                raw_ff, raw_in;
   logic [LENGTH_W-1:0] left_ff, left_in;
   logic [BYTE_W-1:0]   pending_ff, pending_in;
   logic [BYTE_W-1:0]   count_hi_ff, count_hi_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic                trunc_ff, trunc_in;

   logic                out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]   out_value_ff, out_value_in;
   logic [LENGTH_W-1:0] out_length_ff, out_length_in;
   logic                out_done_ff, out_done_in;
   status_type          out_status_ff, out_status_in;

   logic                step, data_step, last;
   logic [LENGTH_W-1:0] add_amt;
   logic [TOTAL_W:0]    sum;
   logic [TOTAL_W-1:0]  total_sat;
   status_type          end_status;

   assign step      = head_valid & (~out_valid_ff | rsp_tready);
   assign pop       = step;
   assign data_step = step & ~head_item.is_begin & in_track_ff;
   assign last      = (left_ff <= 16'd1);
   assign add_amt   = (phase_ff == PH_COUNT_LO) ? {count_hi_ff, head_item.data} : 16'd1;
   assign sum       = {1'b0, total_ff} + {{(TOTAL_W + 1 - LENGTH_W){1'b0}}, add_amt};
   assign total_sat = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
   assign end_status = !last ? ST_OK :
                       (total_sat != track_size(sectors)) ? ST_SIZE : ST_OK;

   // Escape sequencer next state
   always_comb begin
      phase_in = phase_ff;
      if (step && head_item.is_begin) begin
         phase_in = PH_LITERAL;
      end else if (data_step && !raw_ff && !trunc_ff) begin
         unique case (phase_ff)
            PH_LITERAL: begin
               if (head_item.escape && left_ff > ESCAPE_LAST) begin
                  phase_in = PH_VALUE;
               end
            end
            PH_VALUE:    phase_in = PH_COUNT_HI;
            PH_COUNT_HI: phase_in = PH_COUNT_LO;
            PH_COUNT_LO: phase_in = PH_LITERAL;
            default:     phase_in = PH_LITERAL;
         endcase
      end
   end

   // Sequencer outputs and datapath
   always_comb begin
      in_track_in   = in_track_ff;
      raw_in        = raw_ff;
      left_in       = left_ff;
      pending_in    = pending_ff;
      count_hi_in   = count_hi_ff;
      total_in      = total_ff;
      trunc_in      = trunc_ff;
      out_valid_in  = out_valid_ff & ~rsp_tready;
      out_value_in  = out_value_ff;
      out_length_in = out_length_ff;
      out_done_in   = out_done_ff;
      out_status_in = out_status_ff;

      if (step && head_item.is_begin) begin
         raw_in      = head_item.raw;
         left_in     = head_item.length;
         pending_in  = '0;
         count_hi_in = '0;
         total_in    = '0;
         trunc_in    = 1'b0;
         in_track_in = ~head_item.zero;
         if (head_item.zero) begin
            out_valid_in  = 1'b1;
            out_value_in  = '0;
            out_length_in = '0;
            out_done_in   = 1'b1;
            out_status_in = head_item.size_nonzero ? ST_SIZE : ST_OK;
         end
      end else if (data_step) begin
         left_in     = last ? '0 : left_ff - 1'b1;
         in_track_in = ~last;
         if (raw_ff) begin
            total_in      = total_sat;
            out_valid_in  = 1'b1;
            out_value_in  = head_item.data;
            out_length_in = 16'd1;
            out_done_in   = last;
            out_status_in = ST_OK;
         end else if (trunc_ff) begin
            if (last) begin
               out_valid_in  = 1'b1;
               out_value_in  = '0;
               out_length_in = '0;
               out_done_in   = 1'b1;
               out_status_in = ST_TRUNC;
            end
         end else begin
            unique case (phase_ff)
               PH_LITERAL: begin
                  if (!head_item.escape) begin
                     total_in      = total_sat;
                     out_valid_in  = 1'b1;
                     out_value_in  = head_item.data;
                     out_length_in = 16'd1;
                     out_done_in   = last;
                     out_status_in = end_status;
                  end else if (left_ff <= ESCAPE_LAST) begin
                     trunc_in = 1'b1;
                     if (last) begin
                        out_valid_in  = 1'b1;
                        out_value_in  = '0;
                        out_length_in = '0;
                        out_done_in   = 1'b1;
                        out_status_in = ST_TRUNC;
                     end
                  end
               end
               PH_VALUE:    pending_in  = head_item.data;
               PH_COUNT_HI: count_hi_in = head_item.data;
               PH_COUNT_LO: begin
                  total_in      = total_sat;
                  out_valid_in  = 1'b1;
                  out_value_in  = pending_ff;
                  out_length_in = add_amt;
                  out_done_in   = last;
                  out_status_in = end_status;
               end
               default: begin
                  pending_in = pending_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LITERAL;
         in_track_ff  <= 1'b0;
         raw_ff       <= 1'b0;
         left_ff      <= '0;
         pending_ff   <= '0;
         count_hi_ff  <= '0;
         total_ff     <= '0;
         trunc_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         in_track_ff  <= in_track_in;
         raw_ff       <= raw_in;
         left_ff      <= left_in;
         pending_ff   <= pending_in;
         count_hi_ff  <= count_hi_in;
         total_ff     <= total_in;
         trunc_ff     <= trunc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_value_ff  <= out_value_in;
      out_length_ff <= out_length_in;
      out_done_ff   <= out_done_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_length_ff, out_value_ff};
   assign rsp_tlast  = out_done_ff;
   assign rsp_tuser  = out_status_ff;

endmodule

FILE: design/msa_track_rle_decoder.sv
// ----------------------------------------------------------------------------
// msa_track_rle_decoder
// Decodes MSA disk image track bytes into run descriptors with end status.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  req_     | in        | tuser opcode, tdata stored_length / data_byte
//  rsp_     | out       | tdata run_value / run_length, tlast done, tuser status
//  csr_     | in        | sectors_per_track write
//
//  One transaction per cycle while rsp_ is not stalled; a transaction is written
//  into the queue at the accept edge, and its result then passes through the
//  output register before rsp_tvalid rises.
//  The queue of QUEUE_DEPTH entries absorbs rsp_ stalls; req_tready drops
//  only when it is full. Synchronous active-high reset empties the queue
//  and clears track state; sectors_per_track returns to 9.
// ----------------------------------------------------------------------------
module msa_track_rle_decoder import mtrd_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [23:0]         req_tdata,   // stored_length[15:0], data_byte[23:16]
   input  logic                req_tuser,   // opcode
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [23:0]         rsp_tdata,   // run_value[7:0], run_length[23:8]
   output logic                rsp_tlast,
   output logic [1:0]          rsp_tuser,   // status
   input  logic                csr_wr_en,
   input  logic [SECTOR_W-1:0] csr_wr_data
);

   logic [SECTOR_W-1:0] sectors_ff;
   item_type            front_item;
   item_type            head_item;
   logic                full, head_valid, pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         sectors_ff <= SECTORS_RESET;
      end else if (csr_wr_en) begin
         sectors_ff <= csr_wr_data;
      end
   end

   assign req_tready = ~full;

   mtrd_front u_front (
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .sectors   (sectors_ff),
      .item      (front_item)
   );

   mtrd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_tvalid),
      .push_item  (front_item),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   mtrd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .sectors    (sectors_ff),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: design/mtrd_checker.sv
// ----------------------------------------------------------------------------
// mtrd_checker
// Port-level assertions for the MSA track RLE decoder.
// ----------------------------------------------------------------------------
module mtrd_checker import mtrd_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [1:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("rsp transaction changed while stalled");

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   a_status_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tlast)
      else $error("nonzero status on a result that is not the track end");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == ST_OK || rsp_tuser == ST_TRUNC || rsp_tuser == ST_SIZE)
      else $error("undefined status code");

   a_trunc_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_TRUNC |-> rsp_tdata == 24'd0)
      else $error("truncation result carries a run");

endmodule

bind msa_track_rle_decoder mtrd_checker u_mtrd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

FILE: tb/msa_track_rle_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// msa_track_rle_decoder_tb
// Self-checking bench for the MSA track RLE decoder. Track transactions are
// queued per phase and sent by a clocked driver with random gaps in most
// phases. A clocked monitor predicts each run descriptor from its own copy of
// the track state and checks it against rsp_. Phases sweep the sector count.
// ----------------------------------------------------------------------------
module msa_track_rle_decoder_tb;
   import mtrd_pkg::*;

   localparam logic OP_BEGIN    = 1'b0;
   localparam logic OP_BYTE     = 1'b1;
   localparam int   ESC_SPAN    = 4;
   localparam int   STUCK_LIMIT = 2000;
   localparam int   LONG_HOLD   = 300;
   localparam int   QUIET_WAIT  = 8;

   typedef enum int {
      PACE_NONE,
      PACE_FULL,
      PACE_SPARSE
   } pace_type;

   typedef struct packed {
      logic                op;
      logic [LENGTH_W-1:0] len;
      logic [BYTE_W-1:0]   data;
   } track_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   value;
      logic [LENGTH_W-1:0] length;
      logic                done;
      status_type          status;
   } run_desc_type;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [23:0]         req_tdata   = '0;   // stored_length[15:0], data_byte[23:16]
   logic                req_tuser   = 1'b0; // opcode
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [23:0]         rsp_tdata;          // run_value[7:0], run_length[23:8]
   logic                rsp_tlast;
   logic [1:0]          rsp_tuser;          // status
   logic                csr_wr_en   = 1'b0;
   logic [SECTOR_W-1:0] csr_wr_data = '0;

   msa_track_rle_decoder uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   track_item_type byte_feed[$];
   run_desc_type   runs_due[$];
   logic [7:0]     body[$];
   int             fed;
   int             mismatch_count = 0;
   int             stuck_cycles   = 0;
   pace_type       tx_mode        = PACE_SPARSE;
   pace_type       rx_mode        = PACE_SPARSE;
   int             tx_wait        = 0;
   int             rx_wait        = 0;
   int             rx_hold        = 0;
   logic           hold_request   = 1'b0;
   logic           hold_served    = 1'b0;
   logic           req_taken      = 1'b0;
   logic           rsp_taken      = 1'b0;

   // track state copy
   logic [SECTOR_W-1:0] m_sectors = SECTORS_RESET;
   logic                m_active  = 1'b0;
   logic                m_raw     = 1'b0;
   logic [LENGTH_W-1:0] m_left    = '0;
   phase_type           m_phase   = PH_LITERAL;
   logic [BYTE_W-1:0]   m_value   = '0;
   logic [BYTE_W-1:0]   m_cnt_hi  = '0;
   logic [TOTAL_W-1:0]  m_total   = '0;
   logic                m_trunc   = 1'b0;

   function automatic int pause_draw(input pace_type mode);
      case (mode)
         PACE_NONE: return 0;
         PACE_FULL: return $urandom_range(0, 19);
         default:   return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
      endcase
   endfunction

   function automatic run_desc_type make_run(input logic [7:0] v, input logic [15:0] l,
                                             input logic d, input status_type s);
      run_desc_type r;
      r.value  = v;
      r.length = l;
      r.done   = d;
      r.status = d ? s : ST_OK;
      return r;
   endfunction

   function automatic void accumulate(input logic [15:0] n);
      logic [TOTAL_W:0] sum;
      sum = {1'b0, m_total} + {2'b00, n};
      m_total = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
   endfunction

   function automatic status_type end_status(input logic [TOTAL_W-1:0] size);
      if (m_trunc)
         return ST_TRUNC;
      return (m_total != size) ? ST_SIZE : ST_OK;
   endfunction

   task automatic decode_step(input track_item_type it, output logic has_run,
                              output run_desc_type rd);
      logic [TOTAL_W-1:0] size;
      logic               last;
      size    = {1'b0, m_sectors, 9'd0};
      has_run = 1'b0;
      rd      = '0;
      if (it.op == OP_BEGIN) begin
         m_raw    = ({1'b0, it.len} == size);
         m_left   = it.len;
         m_phase  = PH_LITERAL;
         m_value  = '0;
         m_cnt_hi = '0;
         m_total  = '0;
         m_trunc  = 1'b0;
         m_active = (it.len != '0);
         if (it.len == '0) begin
            has_run = 1'b1;
            rd = make_run(8'd0, 16'd0, 1'b1, end_status(size));
         end
      end else if (m_active) begin
         last   = (m_left <= 16'd1);
         m_left = last ? 16'd0 : m_left - 16'd1;
         if (last)
            m_active = 1'b0;
         if (m_raw) begin
            accumulate(16'd1);
            has_run = 1'b1;
            rd = make_run(it.data, 16'd1, last, ST_OK);
         end else if (m_trunc) begin
            has_run = last;
            rd = make_run(8'd0, 16'd0, 1'b1, ST_TRUNC);
         end else begin
            case (m_phase)
               PH_LITERAL: begin
                  if (it.data != ESCAPE_BYTE) begin
                     accumulate(16'd1);
                     has_run = 1'b1;
                     rd = make_run(it.data, 16'd1, last, end_status(size));
                  end else if (int'(m_left) + 1 < ESC_SPAN) begin
                     m_trunc = 1'b1;
                     has_run = last;
                     rd = make_run(8'd0, 16'd0, 1'b1, ST_TRUNC);
                  end else begin
                     m_phase = PH_VALUE;
                  end
               end
               PH_VALUE: begin
                  m_value = it.data;
                  m_phase = PH_COUNT_HI;
               end
               PH_COUNT_HI: begin
                  m_cnt_hi = it.data;
                  m_phase  = PH_COUNT_LO;
               end
               default: begin
                  m_phase = PH_LITERAL;
                  accumulate({m_cnt_hi, it.data});
                  has_run = 1'b1;
                  rd = make_run(m_value, {m_cnt_hi, it.data}, last, end_status(size));
               end
            endcase
         end
      end
   endtask

   task automatic report(input string what);
      if (mismatch_count < 100)
         $display("[%0t] mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------
   // stimulus builders
   // ------------------------------------------------------------------
   function automatic track_item_type make_item(input logic op, input logic [15:0] len,
                                                input logic [7:0] data);
      track_item_type it;
      it.op   = op;
      it.len  = len;
      it.data = data;
      return it;
   endfunction

   task automatic put_begin(input logic [15:0] len);
      byte_feed.insert(byte_feed.size(), make_item(OP_BEGIN, len, 8'($urandom)));
      fed++;
   endtask

   task automatic put_byte(input logic [7:0] b);
      byte_feed.insert(byte_feed.size(), make_item(OP_BYTE, 16'($urandom), b));
      fed++;
   endtask

   task automatic add_run(input logic [7:0] v, input logic [15:0] c);
      body.insert(body.size(), ESCAPE_BYTE);
      body.insert(body.size(), v);
      body.insert(body.size(), c[15:8]);
      body.insert(body.size(), c[7:0]);
   endtask

   task automatic add_literal();
      logic [7:0] b;
      b = 8'($urandom);
      if (b == ESCAPE_BYTE)
         add_run(ESCAPE_BYTE, 16'd1);
      else
         body.insert(body.size(), b);
   endtask

   task automatic flush_track();
      put_begin(16'(body.size()));
      foreach (body[i])
         put_byte(body[i]);
      body.delete();
   endtask

   // runs and literals that add up to the track size exactly
   task automatic build_exact(input int size);
      int rem;
      int n;
      int c;
      rem = size;
      n   = $urandom_range(1, 8);
      for (int i = 0; i < n - 1; i++) begin
         if (rem > 0 && $urandom_range(0, 1) == 1) begin
            add_literal();
            rem--;
         end else begin
            c = $urandom_range(0, rem);
            add_run(8'($urandom), 16'(c));
            rem -= c;
         end
      end
      add_run(8'($urandom), 16'(rem));
   endtask

   task automatic build_loose(input int n);
      int sel;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(0, 9);
         if (sel < 3)
            add_literal();
         else if (sel < 5)
            add_run(8'($urandom), 16'hFFFF);
         else if (sel < 6)
            add_run(8'($urandom), 16'd0);
         else
            add_run(8'($urandom), 16'($urandom));
      end
   endtask

   task automatic gen_track(input int size);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         build_exact(size);
         flush_track();
      end else if (pick < 65) begin
         build_loose($urandom_range(1, 6));
         flush_track();
      end else if (pick < 70) begin
         // total saturates
         repeat (3) add_run(8'($urandom), 16'hFFFF);
         build_loose($urandom_range(0, 2));
         flush_track();
      end else if (pick < 80) begin
         // escape cut short by the track end
         build_loose($urandom_range(0, 2));
         body.insert(body.size(), ESCAPE_BYTE);
         repeat ($urandom_range(0, 2)) body.insert(body.size(), 8'($urandom));
         flush_track();
         if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3))
               byte_feed.insert(byte_feed.size(),
                                make_item(OP_BYTE, 16'($urandom), 8'($urandom)));
      end else if (pick < 87) begin
         // raw track, abandoned by the next begin
         put_begin(16'(size));
         repeat ($urandom_range(1, 20))
            put_byte(($urandom_range(0, 3) == 0) ? ESCAPE_BYTE : 8'($urandom));
      end else if (pick < 94) begin
         put_begin(16'($urandom));
         repeat ($urandom_range(0, 12))
            put_byte(($urandom_range(0, 1) == 1) ? ESCAPE_BYTE : 8'($urandom));
      end else begin
         put_begin(16'd0);
      end
   endtask

   task automatic wait_quiet();
      while (byte_feed.size() != 0 || req_tvalid || runs_due.size() != 0)
         @(posedge clock);
      repeat (QUIET_WAIT) @(posedge clock);
   endtask

   task automatic set_sectors(input logic [SECTOR_W-1:0] v);
      wait_quiet();
      @(negedge clock);
      csr_wr_data <= v;
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // driver
   // ------------------------------------------------------------------
   always @(negedge clock) begin : feed_drive
      track_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         tx_wait    <= 0;
      end else if (!req_tvalid || req_taken) begin
         if (tx_wait > 0) begin
            tx_wait    <= tx_wait - 1;
            req_tvalid <= 1'b0;
         end else if (byte_feed.size() != 0) begin
            nxt = byte_feed.pop_front();
            req_tuser  <= nxt.op;
            req_tdata  <= {nxt.data, nxt.len};
            req_tvalid <= 1'b1;
            tx_wait    <= pause_draw(tx_mode);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // receiver
   // ------------------------------------------------------------------
   always @(negedge clock) begin : sink_drive
      int stall;
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_wait    <= 0;
      end else if (hold_request && !hold_served) begin
         hold_served <= 1'b1;
         rx_hold     <= LONG_HOLD;
         rsp_tready  <= 1'b0;
      end else if (rx_hold > 0) begin
         rx_hold    <= rx_hold - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_taken) begin
         stall = pause_draw(rx_mode);
         rsp_tready <= (stall == 0);
         rx_wait    <= (stall == 0) ? 0 : stall - 1;
      end else if (rx_wait > 0) begin
         rx_wait    <= rx_wait - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // monitor and checker
   // ------------------------------------------------------------------
   always @(posedge clock) begin : score
      run_desc_type   want;
      run_desc_type   next_run;
      logic           hit;
      track_item_type seen;
      req_taken <= !reset && req_tvalid && req_tready;
      rsp_taken <= !reset && rsp_tvalid && rsp_tready;
      if (reset) begin
         m_sectors = SECTORS_RESET;
         m_active  = 1'b0;
         m_raw     = 1'b0;
         m_left    = '0;
         m_phase   = PH_LITERAL;
         m_value   = '0;
         m_cnt_hi  = '0;
         m_total   = '0;
         m_trunc   = 1'b0;
      end else begin
         if (csr_wr_en)
            m_sectors = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (runs_due.size() == 0) begin
               report($sformatf("unexpected result value %h length %h",
                                rsp_tdata[7:0], rsp_tdata[23:8]));
            end else begin
               want = runs_due.pop_front();
               if (rsp_tdata[7:0] != want.value)
                  report($sformatf("run_value %h, expected %h", rsp_tdata[7:0], want.value));
               if (rsp_tdata[23:8] != want.length)
                  report($sformatf("run_length %h, expected %h", rsp_tdata[23:8],
                                   want.length));
               if (rsp_tlast != want.done)
                  report($sformatf("track_done %b, expected %b", rsp_tlast, want.done));
               if (rsp_tuser != want.status)
                  report($sformatf("status %0d, expected %0d", rsp_tuser, want.status));
            end
         end
         if (req_tvalid && req_tready) begin
            seen = make_item(req_tuser, req_tdata[15:0], req_tdata[23:16]);
            decode_step(seen, hit, next_run);
            if (hit)
               runs_due.insert(runs_due.size(), next_run);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------
   initial begin : stimulus
      int                  budget;
      logic [SECTOR_W-1:0] s;
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      @(posedge clock);

      // reset sector count: empty track, then one run filling 9 sectors
      put_begin(16'd0);
      add_run(8'h7F, 16'h1200);
      flush_track();

      set_sectors(7'd1);
      // escape with three bytes left truncates; result only at the last byte
      body.insert(body.size(), 8'h01);
      body.insert(body.size(), ESCAPE_BYTE);
      body.insert(body.size(), 8'h02);
      body.insert(body.size(), 8'h03);
      flush_track();
      put_byte(8'h5A);                 // outside a track
      put_begin(16'hFFFF);             // abandoned by the next begin
      put_byte(8'h01);
      put_begin(16'd1);
      put_byte(8'hFF);
      put_begin(16'd512);              // raw: escape code passes as a literal
      put_byte(ESCAPE_BYTE);
      put_byte(8'h00);
      put_begin(16'd1);                // escape is the last stored byte
      put_byte(ESCAPE_BYTE);
      add_run(8'h33, 16'd0);
      add_run(8'h33, 16'd511);
      body.insert(body.size(), 8'h44);
      flush_track();

      for (int p = 0; p < 6; p++) begin
         case (p)
            0:       s = 7'd1;
            1:       s = 7'd127;
            2:       s = 7'd9;
            3:       s = 7'd64;
            4:       s = 7'($urandom_range(2, 126));
            default: s = 7'd1;
         endcase
         set_sectors(s);
         case (p)
            0:       begin tx_mode = PACE_FULL;   rx_mode = PACE_FULL;   end
            1:       begin tx_mode = PACE_NONE;   rx_mode = PACE_NONE;   end
            2:       begin tx_mode = PACE_SPARSE; rx_mode = PACE_FULL;   end
            3:       begin tx_mode = PACE_FULL;   rx_mode = PACE_SPARSE; end
            4:       begin tx_mode = PACE_NONE;   rx_mode = PACE_FULL;   end
            default: begin tx_mode = PACE_FULL;   rx_mode = PACE_NONE;   end
         endcase
         fed    = 0;
         budget = (p == 0) ? 570 : 58;
         if (p == 0) begin
            // one full raw track
            put_begin(16'd512);
            repeat (512) put_byte(8'($urandom));
         end
         while (fed < budget)
            gen_track(int'(s) * 512);
         put_begin(16'd0);             // close any open track before the next write
         if (p == 1)
            hold_request <= 1'b1;
      end

      wait_quiet();
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

FILE: files.f
design/mtrd_pkg.sv
design/mtrd_front.sv
design/mtrd_queue.sv
design/mtrd_back.sv
design/msa_track_rle_decoder.sv
design/mtrd_checker.sv
tb/msa_track_rle_decoder_tb.sv
